### rtl/core/mfba_pkg.sv
// Shared constants and controller/datapath interface types for the max-flow block.
`default_nettype none
package mfba_pkg;
	localparam int NODES    = 8;
	localparam int NODE_W   = 3;
	localparam int ADDR_W   = 2 * NODE_W;
	localparam int ENTRIES  = NODES * NODES;
	localparam int CAP_BITS = 16;
	localparam int RES_W    = CAP_BITS + 2;
	localparam int FLOW_W   = 19;
	localparam int CNT_W    = NODE_W + 1;
	localparam logic [FLOW_W-1:0] FLOW_MAX = {FLOW_W{1'b1}};
	localparam logic [0:0] OP_WRITE = 1'b0;
	localparam logic [0:0] OP_RUN   = 1'b1;

	typedef struct packed {
		logic wr_cap;
		logic run_init;
		logic bfs_init;
		logic pop;
		logic scan_rd;
		logic scan_ev;
		logic walk_init;
		logic aug_init;
		logic walk_rd;
		logic min_ev;
		logic sub_wr;
		logic add_wr;
		logic flow_add;
		logic out_load;
		logic out_bad;
	} dp_cmd_t;

	typedef struct packed {
		logic same_node;
		logic q_empty;
		logic scan_last;
		logic sink_hit;
		logic walk_more;
		logic out_free;
	} dp_sts_t;
endpackage
`default_nettype wire

### rtl/core/mfba_dp.sv
// Datapath: residual matrix memory, search registers, path walk and result register.
`default_nettype none
module mfba_dp
	import mfba_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dp_cmd_t           cmd,
	output dp_sts_t                sts,
	input  wire logic [2:0]        row_node,
	input  wire logic [2:0]        col_node,
	input  wire logic [15:0]       capacity,
	input  wire logic [2:0]        source_node,
	input  wire logic [2:0]        sink_node,
	input  wire logic              out_stall,
	output logic                   out_valid,
	output logic [FLOW_W-1:0]      total_flow,
	output logic                   bad_request
);
	logic [RES_W-1:0]  mem [ENTRIES];
	logic [ENTRIES-1:0] vld_q;
	logic [RES_W-1:0]  rd_q;
	logic              rd_vld_q;
	logic [NODE_W-1:0] src_q, dst_q, u_q, v_q, p_q;
	logic [NODE_W-1:0] parent_q [NODES];
	logic [NODE_W-1:0] queue_q [NODES];
	logic [NODES-1:0]  vis_q;
	logic [CNT_W-1:0]  head_q, tail_q, steps_q;
	logic [RES_W-1:0]  bott_q;
	logic [FLOW_W-1:0] flow_q;
	logic              out_vld_q;
	logic [FLOW_W-1:0] out_flow_q;
	logic              out_bad_q;

	logic [RES_W-1:0]  rd_eff;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic [RES_W-1:0]  wr_data;
	logic              wr_en;
	logic [NODE_W-1:0] par_v;
	logic [FLOW_W:0]   flow_sum;

	assign rd_eff = rd_vld_q ? rd_q : '0;
	assign par_v  = parent_q[v_q];
	assign flow_sum = {1'b0, flow_q} + {{(FLOW_W+1-RES_W){1'b0}}, bott_q};

	always_comb begin
		rd_addr = {u_q, v_q};
		if (cmd.walk_rd) begin
			rd_addr = {par_v, v_q};
		end else if (cmd.sub_wr) begin
			rd_addr = {v_q, p_q};
		end
		wr_en   = cmd.wr_cap | cmd.sub_wr | cmd.add_wr;
		wr_addr = {row_node, col_node};
		wr_data = {{(RES_W-CAP_BITS){1'b0}}, capacity[CAP_BITS-1:0]};
		if (cmd.sub_wr) begin
			wr_addr = {p_q, v_q};
			wr_data = rd_eff - bott_q;
		end else if (cmd.add_wr) begin
			wr_addr = {v_q, p_q};
			wr_data = rd_eff + bott_q;
		end
	end

	// matrix storage, no reset; validity tracked per entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[rd_addr] | (wr_en & (wr_addr == rd_addr) & 1'b0);
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	// search and walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vis_q   <= '0;
			flow_q  <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			steps_q <= '0;
		end else begin
			if (cmd.run_init) begin
				flow_q <= '0;
			end
			if (cmd.flow_add) begin
				flow_q <= (flow_sum > {1'b0, FLOW_MAX}) ? FLOW_MAX : flow_sum[FLOW_W-1:0];
			end
			if (cmd.bfs_init) begin
				vis_q  <= NODES'(1) << src_q;
				head_q <= '0;
				tail_q <= CNT_W'(1);
			end
			if (cmd.pop) begin
				head_q <= head_q + CNT_W'(1);
			end
			if (cmd.scan_ev && !vis_q[v_q] && rd_eff != '0 && tail_q < CNT_W'(NODES)) begin
				vis_q[v_q] <= 1'b1;
				tail_q     <= tail_q + CNT_W'(1);
			end
			if (cmd.walk_init || cmd.aug_init) begin
				steps_q <= '0;
			end
			if (cmd.min_ev || cmd.add_wr) begin
				steps_q <= steps_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.run_init) begin
			src_q <= source_node;
			dst_q <= sink_node;
		end
		if (cmd.bfs_init) begin
			parent_q[src_q] <= src_q;
			queue_q[0]      <= src_q;
		end
		if (cmd.pop) begin
			u_q <= queue_q[head_q[NODE_W-1:0]];
			v_q <= '0;
		end
		if (cmd.scan_ev) begin
			v_q <= v_q + NODE_W'(1);
			if (!vis_q[v_q] && rd_eff != '0 && tail_q < CNT_W'(NODES)) begin
				queue_q[tail_q[NODE_W-1:0]] <= v_q;
				parent_q[v_q]               <= u_q;
			end
		end
		if (cmd.walk_init || cmd.aug_init) begin
			v_q <= dst_q;
		end
		if (cmd.walk_init) begin
			bott_q <= '1;
		end
		if (cmd.walk_rd) begin
			p_q <= par_v;
		end
		if (cmd.min_ev) begin
			if (rd_eff < bott_q) begin
				bott_q <= rd_eff;
			end
			v_q <= p_q;
		end
		if (cmd.add_wr) begin
			v_q <= p_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_flow_q <= cmd.out_bad ? '0 : flow_q;
			out_bad_q  <= cmd.out_bad;
		end
	end

	assign sts.same_node = (src_q == dst_q);
	assign sts.q_empty   = (head_q == tail_q);
	assign sts.scan_last = (v_q == NODE_W'(NODES - 1));
	assign sts.sink_hit  = vis_q[dst_q];
	assign sts.walk_more = (v_q != src_q) && (steps_q < CNT_W'(NODES));
	assign sts.out_free  = !out_vld_q || !out_stall;

	assign out_valid   = out_vld_q;
	assign total_flow  = out_flow_q;
	assign bad_request = out_bad_q;
endmodule
`default_nettype wire

### rtl/core/mfba_ctrl.sv
// Controller state machine sequencing loads, searches, path walks and results.
`default_nettype none
module mfba_ctrl
	import mfba_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	input  wire logic    opcode,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CHK  = 4'd1;
	localparam logic [3:0] S_POP  = 4'd2;
	localparam logic [3:0] S_SRD  = 4'd3;
	localparam logic [3:0] S_SEV  = 4'd4;
	localparam logic [3:0] S_TEST = 4'd5;
	localparam logic [3:0] S_BRD  = 4'd6;
	localparam logic [3:0] S_BEV  = 4'd7;
	localparam logic [3:0] S_ARD  = 4'd8;
	localparam logic [3:0] S_ASUB = 4'd9;
	localparam logic [3:0] S_AADD = 4'd10;
	localparam logic [3:0] S_FIN  = 4'd11;
	localparam logic [3:0] S_FINB = 4'd12;

	logic [3:0] state_q, state_nx;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (opcode == OP_RUN) begin
						cmd.run_init = 1'b1;
						state_nx     = S_CHK;
					end else begin
						cmd.wr_cap = 1'b1;
					end
				end
			end
			S_CHK: begin
				if (sts.same_node) begin
					state_nx = S_FINB;
				end else begin
					cmd.bfs_init = 1'b1;
					state_nx     = S_POP;
				end
			end
			S_POP: begin
				if (sts.q_empty) begin
					state_nx = S_TEST;
				end else begin
					cmd.pop  = 1'b1;
					state_nx = S_SRD;
				end
			end
			S_SRD: begin
				cmd.scan_rd = 1'b1;
				state_nx    = S_SEV;
			end
			S_SEV: begin
				cmd.scan_ev = 1'b1;
				state_nx    = sts.scan_last ? S_POP : S_SRD;
			end
			S_TEST: begin
				if (sts.sink_hit) begin
					cmd.walk_init = 1'b1;
					state_nx      = S_BRD;
				end else begin
					state_nx = S_FIN;
				end
			end
			S_BRD: begin
				if (sts.walk_more) begin
					cmd.walk_rd = 1'b1;
					state_nx    = S_BEV;
				end else begin
					cmd.aug_init = 1'b1;
					state_nx     = S_ARD;
				end
			end
			S_BEV: begin
				cmd.min_ev = 1'b1;
				state_nx   = S_BRD;
			end
			S_ARD: begin
				if (sts.walk_more) begin
					cmd.walk_rd = 1'b1;
					state_nx    = S_ASUB;
				end else begin
					cmd.flow_add = 1'b1;
					cmd.bfs_init = 1'b1;
					state_nx     = S_POP;
				end
			end
			S_ASUB: begin
				cmd.sub_wr = 1'b1;
				state_nx   = S_AADD;
			end
			S_AADD: begin
				cmd.add_wr = 1'b1;
				state_nx   = S_ARD;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			S_FINB: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_bad  = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end
endmodule
`default_nettype wire

### rtl/core/max_flow_bfs_augment.sv
// Top level of the shortest-augmenting-path max-flow engine.
//
//  channel | signals                                       | transaction
//  --------+-----------------------------------------------+-------------------------
//  in      | in_valid, in_stall, opcode, row_node,         | load one capacity entry
//          | col_node, capacity, source_node, sink_node    | or start one flow run
//  out     | out_valid, out_stall, total_flow, bad_request | one result per run
//
// Loads are taken back to back while the engine is idle. A run reads the matrix memory
// once per scanned entry in each search, then walks each augmenting path twice: first
// for its bottleneck, then to subtract and add it along the path.
// Reset clears control state and the per-entry valid bits, so the matrix reads zero.
// A finished result waits in the output register under out_stall while loads go on;
// a second run holds at its end until that register frees up.
`default_nettype none
module max_flow_bfs_augment
	import mfba_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [0:0]        opcode,
	input  wire logic [2:0]        row_node,
	input  wire logic [2:0]        col_node,
	input  wire logic [15:0]       capacity,
	input  wire logic [2:0]        source_node,
	input  wire logic [2:0]        sink_node,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [FLOW_W-1:0]      total_flow,
	output logic                   bad_request
);
	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequence the run
	mfba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (opcode[0]),
		.sts      (sts),
		.cmd      (cmd)
	);

	// hold the matrix and do the search, walk and update work
	mfba_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.row_node    (row_node),
		.col_node    (col_node),
		.capacity    (capacity),
		.source_node (source_node),
		.sink_node   (sink_node),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.total_flow  (total_flow),
		.bad_request (bad_request)
	);
endmodule
`default_nettype wire
